// File: sv/swbc_pkg.sv
// Shared types, codes and helper functions of the set associative write-back cache.
package swbc_pkg;

	localparam int unsigned DEF_WAYS        = 4;
	localparam int unsigned DEF_CACHE_BYTES = 2048;
	localparam int unsigned DEF_LINE_BYTES  = 8;
	localparam int unsigned DEF_ADDR_BITS   = 32;

	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_FILL  = 2'd2;

	localparam logic [1:0] KIND_RESP   = 2'd0;
	localparam logic [1:0] KIND_MREAD  = 2'd1;
	localparam logic [1:0] KIND_MWRITE = 2'd2;
	localparam logic [1:0] KIND_REJECT = 2'd3;

	localparam logic [15:0] LFSR_TAPS = 16'hB400;

	typedef enum logic [1:0] {
		OP_READ,
		OP_WRITE,
		OP_FILL
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_MREAD
	} state_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] address;
		logic [1:0]  size_log2;
		logic [63:0] write_data;
		logic [7:0]  req_id;
		logic [63:0] fill_data;
	} item_t;

	function automatic logic [63:0] merge_line(logic [63:0] line, logic [2:0] off,
			logic [1:0] szl, logic [63:0] wd, int unsigned line_bytes);
		logic [63:0] res;
		int unsigned n;
		int unsigned idx;
		res = line;
		n = 32'd1 << szl;
		if (n > line_bytes) begin
			n = line_bytes;
		end
		for (int unsigned pos = 0; pos < 8; pos++) begin
			idx = pos - 32'(off);
			if (pos >= 32'(off) && idx < n && pos < line_bytes) begin
				res[8*pos +: 8] = wd[8*idx[2:0] +: 8];
			end
			if (pos >= line_bytes) begin
				res[8*pos +: 8] = 8'd0;
			end
		end
		return res;
	endfunction

	function automatic logic [15:0] lfsr_next(logic [15:0] l);
		return {1'b0, l[15:1]} ^ (l[0] ? LFSR_TAPS : 16'd0);
	endfunction

endpackage

// File: sv/swbc_if.sv
// Channel interfaces of the cache: request, result and seed configuration.
interface swbc_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [31:0] address;
	logic [1:0]  size_log2;
	logic [63:0] write_data;
	logic [7:0]  req_id;
	logic [63:0] fill_data;
	modport source (output valid, command, address, size_log2, write_data, req_id,
		fill_data, input ready);
	modport sink (input valid, command, address, size_log2, write_data, req_id,
		fill_data, output ready);
endinterface

interface swbc_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [7:0]  response_id;
	logic [63:0] read_data;
	logic [31:0] mem_address;
	logic [63:0] mem_write_data;
	logic        last_result;
	modport source (output valid, result_kind, response_id, read_data, mem_address,
		mem_write_data, last_result, input ready);
	modport sink (input valid, result_kind, response_id, read_data, mem_address,
		mem_write_data, last_result, output ready);
endinterface

interface swbc_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] replacement_seed;
	modport source (output valid, replacement_seed, input ready);
	modport sink (input valid, replacement_seed, output ready);
endinterface

// File: sv/swbc_front.sv
// Request front end: decodes each beat and queues it for the back end.
module swbc_front (
	input  logic              clk,
	input  logic              arst_n,
	swbc_req_if.sink          req,
	output logic              q_valid,
	output swbc_pkg::item_t   q_item,
	input  logic              q_pop
);

	swbc_pkg::item_t ent_q [2];
	logic            rd_ptr_q;
	logic            wr_ptr_q;
	logic [1:0]      cnt_q;
	logic            keep;
	logic            push;
	swbc_pkg::op_t   op;

	always_comb begin
		keep = 1'b1;
		op = swbc_pkg::OP_READ;
		unique case (req.command)
			swbc_pkg::CMD_READ:  op = swbc_pkg::OP_READ;
			swbc_pkg::CMD_WRITE: op = swbc_pkg::OP_WRITE;
			swbc_pkg::CMD_FILL:  op = swbc_pkg::OP_FILL;
			default:             keep = 1'b0;
		endcase
	end

	assign req.ready = (cnt_q != 2'd2);
	assign push = req.valid && req.ready && keep;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= '{op: op, address: req.address, size_log2: req.size_log2,
				write_data: req.write_data, req_id: req.req_id,
				fill_data: req.fill_data};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule

// File: sv/swbc_back.sv
// Cache back end: tag and line stores, lookup, miss handling, fill and result register.
module swbc_back #(
	parameter int unsigned WAYS        = swbc_pkg::DEF_WAYS,
	parameter int unsigned CACHE_BYTES = swbc_pkg::DEF_CACHE_BYTES,
	parameter int unsigned LINE_BYTES  = swbc_pkg::DEF_LINE_BYTES,
	parameter int unsigned ADDR_BITS   = swbc_pkg::DEF_ADDR_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  swbc_pkg::item_t   q_item,
	output logic              q_pop,
	swbc_cfg_if.sink          cfg,
	swbc_rsp_if.source        rsp
);

	localparam int unsigned LB       = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 0;
	localparam int unsigned SETS_RAW = CACHE_BYTES / LINE_BYTES / WAYS;
	localparam int unsigned SETS     = (SETS_RAW > 0) ? SETS_RAW : 1;
	localparam int unsigned SB       = (SETS > 1) ? $clog2(SETS) : 0;
	localparam int unsigned SETW     = (SB > 0) ? SB : 1;
	localparam int unsigned TSH      = LB + SB;
	localparam int unsigned TAGR     = (ADDR_BITS > TSH) ? ADDR_BITS - TSH : 0;
	localparam int unsigned TAGW     = (TAGR > 0) ? TAGR : 1;
	localparam int unsigned WAYW     = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int unsigned LINEW    = 8 * LINE_BYTES;
	localparam logic [TAGW-1:0] TAG_MASK  = TAGW'((64'd1 << TAGR) - 64'd1);
	localparam logic [31:0]     ADDR_MASK = 32'((64'd1 << ADDR_BITS) - 64'd1);
	localparam logic [63:0]     LINE_MASK = 64'((65'd1 << LINEW) - 65'd1);

	logic [TAGW-1:0]  tag_mem [WAYS][SETS];
	logic [LINEW-1:0] data_mem [WAYS][SETS];
	logic             vld_q [WAYS][SETS];
	logic             dty_q [WAYS][SETS];

	logic [TAGW-1:0]  tag_rd_s1 [WAYS];
	logic [LINEW-1:0] data_rd_s1 [WAYS];
	logic             vld_rd_s1 [WAYS];
	logic             dty_rd_s1 [WAYS];

	swbc_pkg::state_t state_q, state_d;
	swbc_pkg::item_t  cur_q;
	logic [15:0]      lfsr_q;
	logic             busy_q;
	logic [31:0]      p_addr_q;
	logic [1:0]       p_size_q;
	logic             p_write_q;
	logic [63:0]      p_wdata_q;
	logic [7:0]       p_id_q;
	logic [WAYW-1:0]  p_way_q;

	logic             ov_q;
	logic [1:0]       okind_q;
	logic [7:0]       oid_q;
	logic [63:0]      ordata_q;
	logic [31:0]      omaddr_q;
	logic [63:0]      omwdata_q;
	logic             olast_q;

	logic             o_load;
	logic [1:0]       okind_d;
	logic [7:0]       oid_d;
	logic [63:0]      ordata_d;
	logic [31:0]      omaddr_d;
	logic [63:0]      omwdata_d;
	logic             olast_d;
	logic             miss;

	logic [SETW-1:0]  rd_set;
	logic [SETW-1:0]  cur_set;
	logic [TAGW-1:0]  cur_tag;
	logic [2:0]       cur_off;
	logic [SETW-1:0]  p_set;
	logic [TAGW-1:0]  p_tag;
	logic [2:0]       p_off;
	logic             slot;
	logic             hit;
	logic [WAYW-1:0]  hit_way;
	logic [15:0]      lfsr_new;
	logic [WAYW-1:0]  victim;
	logic [63:0]      fill_line;
	logic [63:0]      hit_line;
	logic [31:0]      wb_addr;
	logic [31:0]      rd_addr;

	logic             act;
	logic             we;
	logic             we_tag;
	logic [WAYW-1:0]  we_way;
	logic [SETW-1:0]  we_set;
	logic [LINEW-1:0] we_data;
	logic             we_vld;
	logic             we_dty;

	assign cfg.ready = 1'b1;
	assign slot = !ov_q || rsp.ready;
	assign rd_set = SETW'(q_item.address >> LB) & SETW'(SETS - 1);
	assign cur_set = SETW'(cur_q.address >> LB) & SETW'(SETS - 1);
	assign cur_tag = TAGW'(cur_q.address >> TSH) & TAG_MASK;
	assign cur_off = 3'(cur_q.address) & 3'(LINE_BYTES - 1);
	assign p_set = SETW'(p_addr_q >> LB) & SETW'(SETS - 1);
	assign p_tag = TAGW'(p_addr_q >> TSH) & TAG_MASK;
	assign p_off = 3'(p_addr_q) & 3'(LINE_BYTES - 1);
	assign lfsr_new = swbc_pkg::lfsr_next(lfsr_q);
	assign victim = WAYW'(lfsr_new) & WAYW'(WAYS - 1);
	assign hit_line = 64'(data_rd_s1[hit_way]);
	assign fill_line = p_write_q ? swbc_pkg::merge_line(cur_q.fill_data, p_off, p_size_q,
		p_wdata_q, LINE_BYTES) : (cur_q.fill_data & LINE_MASK);
	assign wb_addr = ((32'(cur_set) << LB) | (32'(tag_rd_s1[victim]) << TSH)) & ADDR_MASK;
	assign rd_addr = ((cur_q.address >> LB) << LB) & ADDR_MASK;
	assign miss = act && cur_q.op != swbc_pkg::OP_FILL && !busy_q && !hit;

	always_comb begin
		hit = 1'b0;
		hit_way = '0;
		for (int unsigned w = 0; w < WAYS; w++) begin
			if (vld_rd_s1[w] && tag_rd_s1[w] == cur_tag) begin
				hit = 1'b1;
				hit_way = WAYW'(w);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		q_pop = 1'b0;
		act = 1'b0;
		unique case (state_q)
			swbc_pkg::ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					state_d = swbc_pkg::ST_LOOK;
				end
			end
			swbc_pkg::ST_LOOK: begin
				if (cur_q.op == swbc_pkg::OP_FILL && !busy_q) begin
					state_d = swbc_pkg::ST_IDLE;
				end else if (slot) begin
					act = 1'b1;
					state_d = swbc_pkg::ST_IDLE;
					if (cur_q.op != swbc_pkg::OP_FILL && !busy_q && !hit
							&& dty_rd_s1[victim]) begin
						state_d = swbc_pkg::ST_MREAD;
					end
				end
			end
			swbc_pkg::ST_MREAD: begin
				if (slot) begin
					state_d = swbc_pkg::ST_IDLE;
				end
			end
			default: state_d = swbc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		we = 1'b0;
		we_tag = 1'b0;
		we_way = hit_way;
		we_set = cur_set;
		we_data = LINEW'(swbc_pkg::merge_line(hit_line, cur_off, cur_q.size_log2,
			cur_q.write_data, LINE_BYTES));
		we_vld = 1'b1;
		we_dty = 1'b1;
		if (act) begin
			if (cur_q.op == swbc_pkg::OP_FILL) begin
				we = 1'b1;
				we_tag = 1'b1;
				we_way = p_way_q;
				we_set = p_set;
				we_data = LINEW'(fill_line);
				we_dty = p_write_q;
			end else if (!busy_q) begin
				if (hit) begin
					we = (cur_q.op == swbc_pkg::OP_WRITE);
				end else begin
					we = 1'b1;
					we_way = victim;
					we_vld = 1'b0;
					we_dty = 1'b0;
				end
			end
		end
	end

	always_comb begin
		o_load = act || (state_q == swbc_pkg::ST_MREAD && slot);
		okind_d = swbc_pkg::KIND_RESP;
		oid_d = '0;
		ordata_d = '0;
		omaddr_d = '0;
		omwdata_d = '0;
		olast_d = 1'b1;
		if (state_q == swbc_pkg::ST_MREAD) begin
			okind_d = swbc_pkg::KIND_MREAD;
			omaddr_d = rd_addr;
		end else if (cur_q.op == swbc_pkg::OP_FILL) begin
			oid_d = p_id_q;
			if (!p_write_q) begin
				ordata_d = fill_line >> {p_off, 3'b000};
			end
		end else if (busy_q) begin
			okind_d = swbc_pkg::KIND_REJECT;
			oid_d = cur_q.req_id;
		end else if (hit) begin
			oid_d = cur_q.req_id;
			if (cur_q.op == swbc_pkg::OP_READ) begin
				ordata_d = hit_line >> {cur_off, 3'b000};
			end
		end else if (dty_rd_s1[victim]) begin
			okind_d = swbc_pkg::KIND_MWRITE;
			omaddr_d = wb_addr;
			omwdata_d = 64'(data_rd_s1[victim]);
			olast_d = 1'b0;
		end else begin
			okind_d = swbc_pkg::KIND_MREAD;
			omaddr_d = rd_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (we && (we_tag || we_vld)) begin
			data_mem[we_way][we_set] <= we_data;
		end
		if (we_tag) begin
			tag_mem[we_way][we_set] <= (cur_q.op == swbc_pkg::OP_FILL) ? p_tag : cur_tag;
		end
		if (q_pop) begin
			cur_q <= q_item;
			for (int unsigned w = 0; w < WAYS; w++) begin
				tag_rd_s1[w] <= tag_mem[w][rd_set];
				data_rd_s1[w] <= data_mem[w][rd_set];
				vld_rd_s1[w] <= vld_q[w][rd_set];
				dty_rd_s1[w] <= dty_q[w][rd_set];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int unsigned w = 0; w < WAYS; w++) begin
				for (int unsigned s = 0; s < SETS; s++) begin
					vld_q[w][s] <= 1'b0;
					dty_q[w][s] <= 1'b0;
				end
			end
		end else if (we) begin
			vld_q[we_way][we_set] <= we_vld;
			dty_q[we_way][we_set] <= we_dty;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swbc_pkg::ST_IDLE;
			lfsr_q <= 16'd1;
			busy_q <= 1'b0;
			p_addr_q <= '0;
			p_size_q <= '0;
			p_write_q <= 1'b0;
			p_wdata_q <= '0;
			p_id_q <= '0;
			p_way_q <= '0;
			ov_q <= 1'b0;
			okind_q <= swbc_pkg::KIND_RESP;
			oid_q <= '0;
			ordata_q <= '0;
			omaddr_q <= '0;
			omwdata_q <= '0;
			olast_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				lfsr_q <= (cfg.replacement_seed != 16'd0) ? cfg.replacement_seed : 16'd1;
			end else if (miss) begin
				lfsr_q <= lfsr_new;
			end
			if (o_load) begin
				ov_q <= 1'b1;
				okind_q <= okind_d;
				oid_q <= oid_d;
				ordata_q <= ordata_d;
				omaddr_q <= omaddr_d;
				omwdata_q <= omwdata_d;
				olast_q <= olast_d;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
			if (act && cur_q.op == swbc_pkg::OP_FILL) begin
				busy_q <= 1'b0;
				p_addr_q <= '0;
				p_size_q <= '0;
				p_write_q <= 1'b0;
				p_wdata_q <= '0;
				p_id_q <= '0;
				p_way_q <= '0;
			end else if (miss) begin
				busy_q <= 1'b1;
				p_addr_q <= cur_q.address;
				p_size_q <= cur_q.size_log2;
				p_write_q <= (cur_q.op == swbc_pkg::OP_WRITE);
				p_wdata_q <= cur_q.write_data;
				p_id_q <= cur_q.req_id;
				p_way_q <= victim;
			end
		end
	end

	assign rsp.valid = ov_q;
	assign rsp.result_kind = okind_q;
	assign rsp.response_id = oid_q;
	assign rsp.read_data = ordata_q;
	assign rsp.mem_address = omaddr_q;
	assign rsp.mem_write_data = omwdata_q;
	assign rsp.last_result = olast_q;

	a_mread_has_wb: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == swbc_pkg::ST_MREAD |-> ov_q)
		else $error("line read pending without a writeback beat in the result register");

	a_miss_emits_mem: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> ov_q && (okind_q == swbc_pkg::KIND_MREAD
			|| okind_q == swbc_pkg::KIND_MWRITE))
		else $error("miss did not issue a memory request");

	a_reject_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && okind_q == swbc_pkg::KIND_REJECT |-> busy_q)
		else $error("request rejected while the cache was not blocked");

endmodule

// File: sv/set_assoc_writeback_cache.sv
// Top level of the blocking set associative write-back cache with random replacement.
// The req channel carries processor reads, processor writes and memory line fills.
// Each beat yields one or two result beats on rsp, the final one with last_result set:
// a processor response, a rejection while a miss is outstanding, or memory requests.
// A miss returns an optional writeback of a dirty victim and then a line read; the
// cache blocks until a fill beat arrives, which installs the line and answers the
// saved request. Requests that arrive while blocked get a busy rejection.
// Fills while not blocked and unknown commands produce no result.
// An accepted beat enters a two entry queue. In the idle state the back end pops it,
// registering the set read from the tag and line stores; in the lookup state it does
// the lookup and store update and loads any result, and it pops no new beat until it
// is back in idle. The line read after a writeback is loaded from the line read state
// once the result register has room. While rsp.ready is low the result register holds
// its beat, the back end waits in the lookup and the queue fills until req.ready drops.
// The cfg channel loads the replacement seed into the victim LFSR and is always ready.
// Reset invalidates every line, clears the queue and the blocked state and sets the
// LFSR to one; no clearing pass is needed.
module set_assoc_writeback_cache #(
	parameter int unsigned WAYS        = swbc_pkg::DEF_WAYS,
	parameter int unsigned CACHE_BYTES = swbc_pkg::DEF_CACHE_BYTES,
	parameter int unsigned LINE_BYTES  = swbc_pkg::DEF_LINE_BYTES,
	parameter int unsigned ADDR_BITS   = swbc_pkg::DEF_ADDR_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	swbc_req_if.sink    req,
	swbc_cfg_if.sink    cfg,
	swbc_rsp_if.source  rsp
);

	logic            q_valid;
	logic            q_pop;
	swbc_pkg::item_t q_item;

	swbc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	swbc_back #(
		.WAYS        (WAYS),
		.CACHE_BYTES (CACHE_BYTES),
		.LINE_BYTES  (LINE_BYTES),
		.ADDR_BITS   (ADDR_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.cfg     (cfg),
		.rsp     (rsp)
	);

endmodule
